// File: sv/integer_square_root_assert.svh
// assertion macros for the integer square root rtl
// expects clk and rst in scope of the module that uses them
`ifndef INTEGER_SQUARE_ROOT_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_ASSERT_SVH

// same-cycle implication
`define ISR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ISR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/isr_pkg.sv
// shared types and constants for the integer square root block
// no dependencies
`timescale 1ns / 1ps

package isr_pkg;

  localparam int ROOT_BITS = 16;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// File: sv/isr_datapath.sv
// digit-by-digit square root datapath, one root bit per step
// depends on isr_pkg
`timescale 1ns / 1ps

module isr_datapath #(
  parameter int INPUT_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  isr_pkg::dp_cmd_t              cmd,
  input  logic [INPUT_BITS-1:0]         radicand,
  output isr_pkg::dp_status_t           status,
  output logic [isr_pkg::ROOT_BITS-1:0] root
);
  import isr_pkg::*;

  localparam int RW   = (INPUT_BITS + 1) / 2;
  localparam int PADW = 2 * RW;
  localparam int CW   = $clog2(RW + 1);
  localparam int EXTW = (RW > ROOT_BITS) ? RW : ROOT_BITS;

  logic [PADW-1:0] xsh;
  logic [RW+1:0]   rem;
  logic [RW-1:0]   acc;
  logic [CW-1:0]   cnt;

  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            ge;
  logic [EXTW-1:0] acc_ext;

  // shift in next two radicand bits and try appending a one
  assign rem_sh  = {rem[RW-1:0], xsh[PADW-1 -: 2]};
  assign trial   = {acc, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign acc_ext = EXTW'(acc);

  assign root        = acc_ext[ROOT_BITS-1:0];
  assign status.last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= CW'(RW - 1);
    end else if (cmd.step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xsh <= PADW'(radicand);
      rem <= '0;
      acc <= '0;
    end else if (cmd.step) begin
      xsh <= xsh << 2;
      rem <= ge ? (rem_sh - trial) : rem_sh;
      acc <= RW'({acc, ge});
    end
  end

endmodule

// File: sv/isr_ctrl.sv
// controller for the integer square root block: accept, iterate, strobe result
// depends on isr_pkg and integer_square_root_assert.svh
`timescale 1ns / 1ps
`include "integer_square_root_assert.svh"

module isr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  isr_pkg::dp_status_t status,
  output isr_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import isr_pkg::*;

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;

  assign cmd.load = start && !busy;
  assign cmd.step = (state == RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= RUN;
            busy  <= 1'b1;
          end
        end
        RUN: begin
          if (status.last) begin
            state <= IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // accepted transaction keeps the block busy
  `ISR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not raise busy")
  // final step yields exactly one strobe and frees the block
  `ISR_ASSERT_NEXT(a_last_done, busy && status.last, done && !busy, "missing result strobe")
  `ISR_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `ISR_ASSERT_NOW(a_done_idle, done, !busy && !cmd.step, "strobe while iterating")

endmodule

// File: sv/integer_square_root.sv
// channel   ports                 handshake
// input     radicand              start high while busy low
// result    root                  done high for one cycle, no backpressure
//
// a transaction yields one root bit per cycle from accept to result
// through a single subtract-compare
// a new start is taken in the cycle done is high
// rst is synchronous and clears the controller and the step counter; no clearing pass
// the receiver cannot stall, the root is valid only in the done cycle
//
// top level: isr_ctrl plus isr_datapath, depends on isr_pkg
`timescale 1ns / 1ps

module integer_square_root #(
  parameter int INPUT_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [INPUT_BITS-1:0]         radicand,
  output logic                          busy,
  output logic                          done,
  output logic [isr_pkg::ROOT_BITS-1:0] root
);
  import isr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  isr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  isr_datapath #(
    .INPUT_BITS (INPUT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .radicand (radicand),
    .status   (status),
    .root     (root)
  );

endmodule
